/* design/blc_pkg.sv */
// Shared types and constants for the battery level classifier.
package blc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LIMIT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LIMIT_W-1:0]  count_t;
  typedef logic [1:0]          level_t;

  // Power levels
  localparam level_t LVL_UNDER  = 2'd0;
  localparam level_t LVL_LOWER  = 2'd1;
  localparam level_t LVL_NORMAL = 2'd2;
  localparam level_t LVL_OVER   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_EXIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_ENTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_ENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_EXIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_ENTER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LIMIT = 3'd6;

  // Reset values
  localparam sample_t RST_UNDER_EXIT   = 12'd1536;
  localparam sample_t RST_UNDER_ENTER  = 12'd1433;
  localparam sample_t RST_LOWER_ENTER  = 12'd1843;
  localparam sample_t RST_NORMAL_ENTER = 12'd1945;
  localparam sample_t RST_OVER_EXIT    = 12'd2764;
  localparam sample_t RST_OVER_ENTER   = 12'd2867;
  localparam count_t  RST_FILTER_LIMIT = 16'd10;

  typedef struct packed {
    sample_t under_exit;
    sample_t under_enter;
    sample_t lower_enter;
    sample_t normal_enter;
    sample_t over_exit;
    sample_t over_enter;
    count_t  filter_limit;
  } cfg_t;

  typedef struct packed {
    logic   hit;
    level_t level;
  } target_t;

endpackage

/* design/blc_cfg_regs.sv */
// Configuration register file: thresholds and debounce limit.
module blc_cfg_regs
  import blc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.under_exit   <= RST_UNDER_EXIT;
      cfg.under_enter  <= RST_UNDER_ENTER;
      cfg.lower_enter  <= RST_LOWER_ENTER;
      cfg.normal_enter <= RST_NORMAL_ENTER;
      cfg.over_exit    <= RST_OVER_EXIT;
      cfg.over_enter   <= RST_OVER_ENTER;
      cfg.filter_limit <= RST_FILTER_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_UNDER_EXIT:   cfg.under_exit   <= cfg_data[SAMPLE_W-1:0];
        REG_UNDER_ENTER:  cfg.under_enter  <= cfg_data[SAMPLE_W-1:0];
        REG_LOWER_ENTER:  cfg.lower_enter  <= cfg_data[SAMPLE_W-1:0];
        REG_NORMAL_ENTER: cfg.normal_enter <= cfg_data[SAMPLE_W-1:0];
        REG_OVER_EXIT:    cfg.over_exit    <= cfg_data[SAMPLE_W-1:0];
        REG_OVER_ENTER:   cfg.over_enter   <= cfg_data[SAMPLE_W-1:0];
        REG_FILTER_LIMIT: cfg.filter_limit <= cfg_data[LIMIT_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule

/* design/blc_target.sv */
// Per-level threshold compare with priority, picks the candidate move.
module blc_target
  import blc_pkg::*;
(
  input  level_t  level,
  input  sample_t sample,
  input  cfg_t    cfg,
  output target_t target
);

  logic gt_over, gt_normal, gt_under_exit;
  logic lt_under, lt_lower, lt_over_exit;

  assign gt_over       = sample > cfg.over_enter;
  assign gt_normal     = sample > cfg.normal_enter;
  assign gt_under_exit = sample > cfg.under_exit;
  assign lt_under      = sample < cfg.under_enter;
  assign lt_lower      = sample < cfg.lower_enter;
  assign lt_over_exit  = sample < cfg.over_exit;

  always_comb begin
    target = '{hit: 1'b0, level: level};
    unique case (level)
      LVL_UNDER: begin
        priority if (gt_over)       target = '{hit: 1'b1, level: LVL_OVER};
        else if (gt_normal)         target = '{hit: 1'b1, level: LVL_NORMAL};
        else if (gt_under_exit)     target = '{hit: 1'b1, level: LVL_LOWER};
      end
      LVL_LOWER: begin
        priority if (gt_over)       target = '{hit: 1'b1, level: LVL_OVER};
        else if (gt_normal)         target = '{hit: 1'b1, level: LVL_NORMAL};
        else if (lt_under)          target = '{hit: 1'b1, level: LVL_UNDER};
      end
      LVL_NORMAL: begin
        priority if (gt_over)       target = '{hit: 1'b1, level: LVL_OVER};
        else if (lt_under)          target = '{hit: 1'b1, level: LVL_UNDER};
        else if (lt_lower)          target = '{hit: 1'b1, level: LVL_LOWER};
      end
      LVL_OVER: begin
        priority if (lt_under)      target = '{hit: 1'b1, level: LVL_UNDER};
        else if (lt_lower)          target = '{hit: 1'b1, level: LVL_LOWER};
        else if (lt_over_exit)      target = '{hit: 1'b1, level: LVL_NORMAL};
      end
      default: ;
    endcase
  end

endmodule

/* design/battery_level_classifier.sv */
// Battery level classifier top: level state, debounce counter, result register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | vbat_sample[11:0]
//   out     | output    | out_valid / out_ready | power_level[1:0], level_changed
//   cfg     | input     | cfg_write             | cfg_index[2:0], cfg_data[15:0]
//
// One request per cycle: a sample is classified in the cycle it is taken and
// its result sits in the output register the next cycle. The one-deep output
// register sets the rate; in_ready holds while the result is taken or empty.
// Synchronous reset returns the level to under-low, clears the counter and
// out_valid (the result payload keeps its value), and loads the register defaults.
// A stalled output blocks new requests only while its result is still held.
module battery_level_classifier
  import blc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   vbat_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            power_level,
  output logic                  level_changed,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  target_t target;
  level_t  level_reg, level_next;
  count_t  debounce_count, debounce_count_next;
  logic    in_fire;

  blc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blc_target u_target (
    .level  (level_reg),
    .sample (vbat_sample),
    .cfg    (cfg),
    .target (target)
  );

  // Output register frees up when its result is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Debounce: no candidate clears the count; a candidate with the count at
  // or past the limit moves the level; otherwise count up.
  always_comb begin
    level_next          = level_reg;
    debounce_count_next = debounce_count;
    priority if (!target.hit) begin
      debounce_count_next = '0;
    end else if (debounce_count >= cfg.filter_limit) begin
      debounce_count_next = '0;
      level_next          = target.level;
    end else begin
      debounce_count_next = debounce_count + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg      <= LVL_UNDER;
      debounce_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        level_reg      <= level_next;
        debounce_count <= debounce_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      power_level   <= level_next;
      level_changed <= (level_next != level_reg);
    end
  end

`ifndef SYNTH
  // Result always mirrors the state just stored.
  a_result_level: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (power_level == level_reg))
    else $error("result level differs from stored level");

  // Changed flag matches a real move of the level.
  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (level_changed == (level_reg != $past(level_reg))))
    else $error("changed flag inconsistent with level move");

  // A move always restarts the debounce count.
  a_move_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (level_next != level_reg)) |=> (debounce_count == '0))
    else $error("counter not cleared on level move");

  // State only changes on an accepted request.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> ($stable(level_reg) && $stable(debounce_count)))
    else $error("state changed without a request");

  // Reset state.
  a_reset: assert property (@(posedge clk)
    rst |=> (level_reg == LVL_UNDER && debounce_count == '0 && !out_valid))
    else $error("bad state after reset");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the battery level classifier: random stalls, config sweeps.
`timescale 1ns / 1ps

module tb_top;
  import blc_pkg::*;

  // Bench knobs
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 150;
  localparam int SETTLE_CYCLES = 4;     // result register is one deep, so a few cycles is plenty
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off for back-pressure
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all before giving up
  localparam int MAX_REPORTS   = 50;    // quiet after this many mismatch lines

  // Index that maps to no register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_ALWAYS} idle_mode_t;

  typedef struct packed {
    level_t level;
    logic   changed;
  } level_result_t;

  // DUT ports; the inputs driven by the bench are at known values from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   vbat_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            power_level;
  logic                  level_changed;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: a private copy of the registers, the level and the debounce counter
  cfg_t   shadow_cfg;
  level_t model_level;
  count_t model_count;

  sample_t       pending_samples[$];   // requests waiting for the driver
  level_result_t level_expect[$];      // predicted results, oldest first

  idle_mode_t send_mode = IDLE_NONE;
  idle_mode_t recv_mode = IDLE_NONE;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  int samples_queued = 0;
  int results_checked = 0;
  int level_moves = 0;
  int settings_used = 0;
  int holds_done = 0;
  int mismatches = 0;

  battery_level_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .vbat_sample   (vbat_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .power_level   (power_level),
    .level_changed (level_changed),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Classify one accepted sample and queue the expected result.
  // Each level checks its thresholds in a fixed priority order; the first hit
  // names the target. No hit clears the counter. A hit counts up until the
  // counter has reached the limit, then the next hit moves the level and clears
  // the counter. A change of target does not clear the counter.
  task automatic predict_level(input sample_t s);
    level_t        prev;
    level_t        target;
    logic          hit;
    level_result_t res;
    prev   = model_level;
    target = model_level;
    hit    = 1'b1;
    case (prev)
      LVL_UNDER: begin
        if (s > shadow_cfg.over_enter) target = LVL_OVER;
        else if (s > shadow_cfg.normal_enter) target = LVL_NORMAL;
        else if (s > shadow_cfg.under_exit) target = LVL_LOWER;
        else hit = 1'b0;
      end
      LVL_LOWER: begin
        if (s > shadow_cfg.over_enter) target = LVL_OVER;
        else if (s > shadow_cfg.normal_enter) target = LVL_NORMAL;
        else if (s < shadow_cfg.under_enter) target = LVL_UNDER;
        else hit = 1'b0;
      end
      LVL_NORMAL: begin
        if (s > shadow_cfg.over_enter) target = LVL_OVER;
        else if (s < shadow_cfg.under_enter) target = LVL_UNDER;
        else if (s < shadow_cfg.lower_enter) target = LVL_LOWER;
        else hit = 1'b0;
      end
      default: begin
        if (s < shadow_cfg.under_enter) target = LVL_UNDER;
        else if (s < shadow_cfg.lower_enter) target = LVL_LOWER;
        else if (s < shadow_cfg.over_exit) target = LVL_NORMAL;
        else hit = 1'b0;
      end
    endcase

    if (!hit) begin
      model_count = '0;
    end else if (model_count >= shadow_cfg.filter_limit) begin
      // covers a limit lowered under the running count and a limit of zero
      model_count = '0;
      model_level = target;
    end else begin
      model_count = model_count + 1'b1;
    end

    res.level   = model_level;
    res.changed = (model_level != prev);
    if (res.changed) level_moves++;
    level_expect.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      default:   return int'($urandom_range(0, 16));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0d at %0t ns, result %0d: %s", mismatches, $time, results_checked,
               what);
  endtask

  // Register write; the shadow copy is updated alongside. Only called while
  // nothing is in flight, so the predictor never sees a half-applied setting.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_UNDER_EXIT:   shadow_cfg.under_exit   = data[SAMPLE_W-1:0];
      REG_UNDER_ENTER:  shadow_cfg.under_enter  = data[SAMPLE_W-1:0];
      REG_LOWER_ENTER:  shadow_cfg.lower_enter  = data[SAMPLE_W-1:0];
      REG_NORMAL_ENTER: shadow_cfg.normal_enter = data[SAMPLE_W-1:0];
      REG_OVER_EXIT:    shadow_cfg.over_exit    = data[SAMPLE_W-1:0];
      REG_OVER_ENTER:   shadow_cfg.over_enter   = data[SAMPLE_W-1:0];
      REG_FILTER_LIMIT: shadow_cfg.filter_limit = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Threshold write with junk in the unused top bits, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] pad_thr(input int thr);
    return CFG_DATA_W'(($urandom_range(0, 15) << SAMPLE_W) | (thr & 12'hFFF));
  endfunction

  task automatic load_cfg(input int under_exit, input int under_enter, input int lower_enter,
                          input int normal_enter, input int over_exit, input int over_enter,
                          input int limit);
    write_reg(REG_UNDER_EXIT, pad_thr(under_exit));
    write_reg(REG_UNDER_ENTER, pad_thr(under_enter));
    write_reg(REG_LOWER_ENTER, pad_thr(lower_enter));
    write_reg(REG_NORMAL_ENTER, pad_thr(normal_enter));
    write_reg(REG_OVER_EXIT, pad_thr(over_exit));
    write_reg(REG_OVER_ENTER, pad_thr(over_enter));
    write_reg(REG_FILTER_LIMIT, CFG_DATA_W'(limit));
    settings_used++;
  endtask

  task automatic queue_sample(input int s);
    pending_samples.push_back(sample_t'(s));
    samples_queued++;
  endtask

  // Mostly runs of near-equal samples so the counter actually reaches the
  // limit and levels move; the rest is single random samples as noise.
  task automatic queue_random(input int count);
    int left, run_len, base, jit, v, pick, max_run;
    left = count;
    max_run = (shadow_cfg.filter_limit > 8) ? 12 : int'(shadow_cfg.filter_limit) + 3;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_sample($urandom_range(0, 4095));
        left--;
      end else begin
        pick = $urandom_range(0, 6);
        case (pick)
          1: base = shadow_cfg.under_exit;
          2: base = shadow_cfg.under_enter;
          3: base = shadow_cfg.lower_enter;
          4: base = shadow_cfg.normal_enter;
          5: base = shadow_cfg.over_exit;
          6: base = shadow_cfg.over_enter;
          default: base = $urandom_range(0, 4095);
        endcase
        jit = $urandom_range(0, 48);
        base = base + jit - 24;
        run_len = $urandom_range(1, max_run);
        for (int k = 0; k < run_len && left > 0; k++) begin
          jit = $urandom_range(0, 16);
          v = base + jit - 8;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          queue_sample(v);
          left--;
        end
      end
    end
  endtask

  // Wait until every queued request has come back, plus a short pause
  task automatic drain();
    while (results_checked < samples_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one sample per request, optional gap after each accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic next_valid;
    if (rst) begin
      in_valid    <= 1'b0;
      vbat_sample <= '0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        predict_level(vbat_sample);
        next_valid = 1'b0;
        send_gap = draw_wait(send_mode);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() != 0) begin
          next_valid = 1'b1;
          vbat_sample <= pending_samples.pop_front();
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    level_result_t want;
    logic          rdy;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (level_expect.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = level_expect.pop_front();
          if (power_level !== want.level)
            report_mismatch($sformatf("power_level %0d, predicted %0d", power_level,
                                      want.level));
          if (level_changed !== want.changed)
            report_mismatch($sformatf("level_changed %0b, predicted %0b", level_changed,
                                      want.changed));
        end
        recv_gap = draw_wait(recv_mode);
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // Long receiver hold-off, counted here; each bump of hold_req starts one
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: %0d cycles without a handshake", STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int t[6];
    int directed_walk[$];

    // With a zero limit every hit moves at once: this walk takes all twelve
    // level-to-level moves, both ADC extremes and samples sitting exactly on
    // a threshold (strict compares, so no move there).
    directed_walk = '{1536, 1537, 1433, 1432, 1946, 1843, 1842, 2868, 2764, 2763,
                      4095, 0, 4095, 1842, 1945, 1946, 1432, 2000, 2868, 1000};

    shadow_cfg = '{RST_UNDER_EXIT, RST_UNDER_ENTER, RST_LOWER_ENTER, RST_NORMAL_ENTER,
                   RST_OVER_EXIT, RST_OVER_ENTER, RST_FILTER_LIMIT};
    model_level = LVL_UNDER;
    model_count = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // First few samples run on the reset defaults
    queue_sample(1600);
    queue_sample(1600);
    drain();

    write_reg(REG_FILTER_LIMIT, '0);
    foreach (directed_walk[k]) queue_sample(directed_walk[k]);
    drain();

    // Unknown index must not touch the limit: with limit 10 restored, six hits
    // build the count without a move. Then drop the limit below the running
    // count and the next hit must move straight away.
    write_reg(REG_FILTER_LIMIT, CFG_DATA_W'(10));
    write_reg(REG_UNUSED, '0);
    repeat (6) queue_sample(1600);
    drain();
    write_reg(REG_FILTER_LIMIT, CFG_DATA_W'(2));
    queue_sample(1600);
    drain();

    // Random phases, each with its own register setting and idling mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_cfg(RST_UNDER_EXIT, RST_UNDER_ENTER, RST_LOWER_ENTER, RST_NORMAL_ENTER,
                    RST_OVER_EXIT, RST_OVER_ENTER, RST_FILTER_LIMIT);
        1: load_cfg(0, 0, 0, 0, 0, 0, 0);
        2: load_cfg(4095, 4095, 4095, 4095, 4095, 4095, 65535);
        default: begin
          foreach (t[k]) t[k] = $urandom_range(0, 4095);
          // even phases get an ordered ladder, odd ones a scrambled one
          if (p % 2 == 0) t.sort();
          load_cfg(t[1], t[0], t[2], t[3], t[4], t[5], $urandom_range(0, 6));
        end
      endcase

      if (p == 0) begin
        send_mode = IDLE_NONE;
        recv_mode = IDLE_NONE;
      end else begin
        send_mode = idle_mode_t'($urandom_range(0, 2));
        recv_mode = idle_mode_t'($urandom_range(0, 2));
      end

      queue_random(PHASE_SAMPLES);

      // Back-pressure phases: sender pushes flat out while the receiver sits
      // on its ready, so the result register fills and in_ready has to drop.
      if (p == 4 || p == 7) begin
        send_mode = IDLE_NONE;
        hold_req <= hold_req + 1;
        holds_done++;
      end
      drain();
    end

    $display("checked %0d classified samples under %0d register settings, %0d level moves",
             results_checked, settings_used, level_moves);
    $display("idle mixes on both sides, %0d long output holds with the input stalled",
             holds_done);
    if (mismatches == 0 && level_expect.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d predictions never matched", mismatches,
               level_expect.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* battery_level_classifier.f */
design/blc_pkg.sv
design/blc_cfg_regs.sv
design/blc_target.sv
design/battery_level_classifier.sv
bench/tb_top.sv
